// ===== hdl/ahra_pkg.sv =====
`default_nettype none
package ahra_pkg;

   localparam int DEF_MAX_HOLES = 64;
   localparam int DEF_ADDR_BITS = 48;

   // operation codes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_CLAIM = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;
   localparam logic [1:0] OP_INIT  = 2'd3;

   // strategy codes
   localparam logic [1:0] STRAT_DEFAULT = 2'd0;
   localparam logic [1:0] STRAT_UP      = 2'd1;
   localparam logic [1:0] STRAT_DOWN    = 2'd2;
   localparam logic [1:0] STRAT_BAD     = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOFIT   = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_INVALID = 2'd3;

   // csr register indexes
   localparam logic [1:0] CSR_HEAP_START = 2'd0;
   localparam logic [1:0] CSR_HEAP_SIZE  = 2'd1;
   localparam logic [1:0] CSR_DEFAULT    = 2'd2;

   // datapath command codes
   localparam logic [4:0] CMD_NONE     = 5'd0;
   localparam logic [4:0] CMD_CAPTURE  = 5'd1;
   localparam logic [4:0] CMD_SCAN_RD  = 5'd2;
   localparam logic [4:0] CMD_NEXT     = 5'd3;
   localparam logic [4:0] CMD_A_START  = 5'd4;
   localparam logic [4:0] CMD_A_EVAL   = 5'd5;
   localparam logic [4:0] CMD_F_LO     = 5'd6;
   localparam logic [4:0] CMD_F_HI     = 5'd7;
   localparam logic [4:0] CMD_RM_CARVE = 5'd8;
   localparam logic [4:0] CMD_MERGE2   = 5'd9;
   localparam logic [4:0] CMD_SPLIT    = 5'd10;
   localparam logic [4:0] CMD_INS_FREE = 5'd11;
   localparam logic [4:0] CMD_RM_RD    = 5'd12;
   localparam logic [4:0] CMD_RM_WR    = 5'd13;
   localparam logic [4:0] CMD_INS_RD   = 5'd14;
   localparam logic [4:0] CMD_INS_WR   = 5'd15;
   localparam logic [4:0] CMD_CNT_DEC  = 5'd16;
   localparam logic [4:0] CMD_INS_PUT  = 5'd17;
   localparam logic [4:0] CMD_WR_BELOW = 5'd18;
   localparam logic [4:0] CMD_WR_TOP   = 5'd19;
   localparam logic [4:0] CMD_LO_GROW  = 5'd20;
   localparam logic [4:0] CMD_HI_GROW  = 5'd21;
   localparam logic [4:0] CMD_FINISH   = 5'd22;

   typedef struct packed {
      logic [4:0] code;
      logic [1:0] status;
   } ahra_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       bad_req;
      logic       scan_end;
      logic       fits;
      logic       rem_done;
      logic       place_ok;
      logic       le_off;
      logic       claim_ok;
      logic       free_bad;
      logic       lo_adj;
      logic       hi_adj;
      logic       below0;
      logic       above0;
      logic       full;
      logic       rm_more;
      logic       ins_more;
      logic       out_busy;
   } ahra_sts_type;

endpackage
`default_nettype wire

// ===== hdl/ahra_ram.sv =====
`default_nettype none
module ahra_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== hdl/ahra_rem.sv =====
`default_nettype none
module ahra_rem #(
   parameter int XW = 48,
   parameter int DW = 49
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [XW-1:0] x,
   input  wire logic [DW-1:0] d,
   output logic               done,
   output logic      [DW-1:0] rem
);

   localparam int NW = $clog2(XW + 1);

   logic [XW-1:0] x_ff, x_in;
   logic [DW-1:0] d_ff, d_in;
   logic [DW-1:0] r_ff, r_in;
   logic [NW-1:0] n_ff, n_in;
   logic          busy_ff, busy_in;
   logic [DW:0]   trial;

   // restoring division, one quotient bit a cycle; only the remainder is kept
   always_comb begin
      x_in    = x_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      n_in    = n_ff;
      busy_in = busy_ff;
      trial   = {r_ff, x_ff[XW-1]};
      if (start) begin
         x_in    = x;
         d_in    = d;
         r_in    = '0;
         n_in    = NW'(XW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in = {x_ff[XW-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = DW'(trial - {1'b0, d_ff});
         end else begin
            r_in = trial[DW-1:0];
         end
         n_in = n_ff - NW'(1);
         if (n_ff == NW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff <= x_in;
      d_ff <= d_in;
      r_ff <= r_in;
      n_ff <= n_in;
   end

   assign done = !busy_ff;
   assign rem  = r_ff;

endmodule
`default_nettype wire

// ===== hdl/ahra_ctrl.sv =====
`default_nettype none
module ahra_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire ahra_pkg::ahra_sts_type sts,
   output ahra_pkg::ahra_cmd_type      cmd
);
   import ahra_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_A_RD   = 4'd2;
   localparam logic [3:0] S_A_CHK  = 4'd3;
   localparam logic [3:0] S_A_DIV  = 4'd4;
   localparam logic [3:0] S_A_EVAL = 4'd5;
   localparam logic [3:0] S_F_RD   = 4'd6;
   localparam logic [3:0] S_F_CHK  = 4'd7;
   localparam logic [3:0] S_F_END  = 4'd8;
   localparam logic [3:0] S_CARVE  = 4'd9;
   localparam logic [3:0] S_R_CHK  = 4'd10;
   localparam logic [3:0] S_R_WR   = 4'd11;
   localparam logic [3:0] S_I_CHK  = 4'd12;
   localparam logic [3:0] S_I_WR   = 4'd13;
   localparam logic [3:0] S_FIN    = 4'd14;

   logic [3:0] state_ff, state_in;
   logic [1:0] stat_ff, stat_in;
   logic [4:0] code;

   always_comb begin
      state_in = state_ff;
      stat_in  = stat_ff;
      code     = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               code     = CMD_CAPTURE;
               stat_in  = STATUS_OK;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.bad_req) begin
               stat_in  = STATUS_INVALID;
               state_in = S_FIN;
            end else if (sts.op == OP_ALLOC) begin
               state_in = S_A_RD;
            end else begin
               state_in = S_F_RD;
            end
         end
         S_A_RD: begin
            if (sts.scan_end) begin
               stat_in  = STATUS_NOFIT;
               state_in = S_FIN;
            end else begin
               code     = CMD_SCAN_RD;
               state_in = S_A_CHK;
            end
         end
         S_A_CHK: begin
            if (sts.fits) begin
               code     = CMD_A_START;
               state_in = S_A_DIV;
            end else begin
               code     = CMD_NEXT;
               state_in = S_A_RD;
            end
         end
         S_A_DIV: begin
            if (sts.rem_done) begin
               state_in = S_A_EVAL;
            end
         end
         S_A_EVAL: begin
            code = CMD_A_EVAL;
            if (sts.place_ok) begin
               state_in = S_CARVE;
            end else begin
               state_in = S_A_RD;
            end
         end
         S_F_RD: begin
            if (sts.scan_end) begin
               state_in = S_F_END;
            end else begin
               code     = CMD_SCAN_RD;
               state_in = S_F_CHK;
            end
         end
         S_F_CHK: begin
            if (sts.le_off) begin
               code     = CMD_F_LO;
               state_in = S_F_RD;
            end else begin
               code     = CMD_F_HI;
               state_in = S_F_END;
            end
         end
         S_F_END: begin
            if (sts.op == OP_CLAIM) begin
               if (sts.claim_ok) begin
                  state_in = S_CARVE;
               end else begin
                  stat_in  = STATUS_NOFIT;
                  state_in = S_FIN;
               end
            end else if (sts.free_bad) begin
               stat_in  = STATUS_INVALID;
               state_in = S_FIN;
            end else if (sts.lo_adj && sts.hi_adj) begin
               code     = CMD_MERGE2;
               state_in = S_R_CHK;
            end else if (sts.lo_adj) begin
               code     = CMD_LO_GROW;
               state_in = S_FIN;
            end else if (sts.hi_adj) begin
               code     = CMD_HI_GROW;
               state_in = S_FIN;
            end else if (sts.full) begin
               stat_in  = STATUS_FULL;
               state_in = S_FIN;
            end else begin
               code     = CMD_INS_FREE;
               state_in = S_I_CHK;
            end
         end
         S_CARVE: begin
            if (sts.below0 && sts.above0) begin
               code     = CMD_RM_CARVE;
               state_in = S_R_CHK;
            end else if (sts.above0) begin
               code     = CMD_WR_BELOW;
               state_in = S_FIN;
            end else if (sts.below0) begin
               code     = CMD_WR_TOP;
               state_in = S_FIN;
            end else if (sts.full) begin
               stat_in  = STATUS_FULL;
               state_in = S_FIN;
            end else begin
               code     = CMD_SPLIT;
               state_in = S_I_CHK;
            end
         end
         S_R_CHK: begin
            if (sts.rm_more) begin
               code     = CMD_RM_RD;
               state_in = S_R_WR;
            end else begin
               code     = CMD_CNT_DEC;
               state_in = S_FIN;
            end
         end
         S_R_WR: begin
            code     = CMD_RM_WR;
            state_in = S_R_CHK;
         end
         S_I_CHK: begin
            if (sts.ins_more) begin
               code     = CMD_INS_RD;
               state_in = S_I_WR;
            end else begin
               code     = CMD_INS_PUT;
               state_in = S_FIN;
            end
         end
         S_I_WR: begin
            code     = CMD_INS_WR;
            state_in = S_I_CHK;
         end
         S_FIN: begin
            // hold until the output register is free
            if (!sts.out_busy) begin
               code     = CMD_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stat_ff  <= STATUS_OK;
      end else begin
         state_ff <= state_in;
         stat_ff  <= stat_in;
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign cmd.code   = code;
   assign cmd.status = stat_ff;

endmodule
`default_nettype wire

// ===== hdl/ahra_dp.sv =====
`default_nettype none
module ahra_dp #(
   parameter int MAX_HOLES = ahra_pkg::DEF_MAX_HOLES,
   parameter int ADDR_BITS = ahra_pkg::DEF_ADDR_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [1:0]             req_operation,
   input  wire logic [ADDR_BITS-1:0]   req_offset,
   input  wire logic [ADDR_BITS:0]     req_size,
   input  wire logic [ADDR_BITS:0]     req_alignment,
   input  wire logic [1:0]             req_strategy,
   input  wire logic                   csr_wen,
   input  wire logic [1:0]             csr_index,
   input  wire logic [ADDR_BITS:0]     csr_wdata,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [1:0]             rsp_status,
   output logic      [ADDR_BITS-1:0]   rsp_placed_offset,
   input  wire ahra_pkg::ahra_cmd_type cmd,
   output ahra_pkg::ahra_sts_type      sts
);
   import ahra_pkg::*;

   localparam int AW = ADDR_BITS;
   localparam int LW = ADDR_BITS + 1;
   localparam int CW = $clog2(MAX_HOLES + 1);
   localparam int IW = $clog2(MAX_HOLES);
   localparam logic [LW-1:0] SPACE_END = {1'b1, {AW{1'b0}}};

   // configuration
   logic [AW-1:0] heap_start_ff;
   logic [LW-1:0] heap_size_ff;
   logic          default_ff;

   // request and scan state
   logic [1:0]    op_ff;
   logic [AW-1:0] off_ff;
   logic [LW-1:0] size_ff;
   logic [LW-1:0] align_ff;
   logic          down_ff;
   logic          strat_bad_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] rd_idx_ff;
   logic          lo_found_ff;
   logic [CW-1:0] lo_idx_ff;
   logic [AW-1:0] lo_s_ff;
   logic [LW-1:0] lo_l_ff;
   logic          hi_found_ff;
   logic [AW-1:0] hi_s_ff;
   logic [LW-1:0] hi_l_ff;
   logic [AW-1:0] at_ff;
   logic [CW-1:0] mv_ff;
   logic [CW-1:0] ins_pos_ff;
   logic [AW-1:0] ins_s_ff;
   logic [LW-1:0] ins_l_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [AW-1:0] rsp_placed_ff;

   // memories
   logic          ram_we_s, ram_we_l, ram_re;
   logic [CW-1:0] ram_waddr, ram_raddr;
   logic [AW-1:0] ram_wdata_s, hs_rd;
   logic [LW-1:0] ram_wdata_l, hl_rd;

   // remainder unit
   logic          rem_start;
   logic [AW-1:0] rem_x;
   logic          rem_done;
   logic [LW-1:0] rem_val;

   // combinational helpers
   logic [CW-1:0] scan_addr;
   logic [CW-1:0] lo_next;
   logic [CW-1:0] hi_pos;
   logic [LW-1:0] room;
   logic [LW-1:0] top_rd;
   logic [LW-1:0] at0;
   logic [LW-1:0] at_dn;
   logic [LW-1:0] pad;
   logic [LW-1:0] slack;
   logic [LW-1:0] at_up;
   logic [AW-1:0] at_calc;
   logic          place_ok;
   logic [LW-1:0] below;
   logic [LW-1:0] above;
   logic [LW-1:0] at_end;
   logic [LW-1:0] lo_end;
   logic [LW-1:0] lo_gap;
   logic [LW-1:0] off_end;
   logic [LW-1:0] hi_gap;
   logic          bad_req;

   ahra_ram #(.WIDTH(AW), .DEPTH(MAX_HOLES)) u_start_ram (
      .clock (clock),
      .we    (ram_we_s),
      .waddr (ram_waddr[IW-1:0]),
      .wdata (ram_wdata_s),
      .re    (ram_re),
      .raddr (ram_raddr[IW-1:0]),
      .rdata (hs_rd)
   );

   ahra_ram #(.WIDTH(LW), .DEPTH(MAX_HOLES)) u_len_ram (
      .clock (clock),
      .we    (ram_we_l),
      .waddr (ram_waddr[IW-1:0]),
      .wdata (ram_wdata_l),
      .re    (ram_re),
      .raddr (ram_raddr[IW-1:0]),
      .rdata (hl_rd)
   );

   ahra_rem #(.XW(AW), .DW(LW)) u_rem (
      .clock (clock),
      .reset (reset),
      .start (rem_start),
      .x     (rem_x),
      .d     (align_ff),
      .done  (rem_done),
      .rem   (rem_val)
   );

   always_comb begin
      scan_addr = down_ff ? (cnt_ff - idx_ff - CW'(1)) : idx_ff;
      lo_next   = lo_idx_ff + CW'(1);
      hi_pos    = lo_found_ff ? lo_next : '0;
      room      = SPACE_END - {1'b0, off_ff};
      if (op_ff == OP_ALLOC) begin
         bad_req = (size_ff == '0) || (align_ff == '0) || strat_bad_ff;
      end else begin
         bad_req = (size_ff == '0) || (size_ff > room);
      end

      // dividend for the remainder: unaligned top placement (hole end minus size) or hole start
      top_rd = {1'b0, hs_rd} + hl_rd - size_ff;
      rem_x  = down_ff ? top_rd[AW-1:0] : hs_rd;

      at0   = {1'b0, lo_s_ff} + lo_l_ff - size_ff;
      at_dn = at0 - rem_val;
      pad   = align_ff - rem_val;
      slack = lo_l_ff - size_ff;
      at_up = {1'b0, lo_s_ff} + ((rem_val == '0) ? '0 : pad);
      if (down_ff) begin
         place_ok = (at_dn >= {1'b0, lo_s_ff});
         at_calc  = at_dn[AW-1:0];
      end else begin
         place_ok = (rem_val == '0) || (pad <= slack);
         at_calc  = at_up[AW-1:0];
      end

      below   = {1'b0, at_ff} - {1'b0, lo_s_ff};
      above   = lo_l_ff - size_ff - below;
      at_end  = {1'b0, at_ff} + size_ff;
      lo_end  = {1'b0, lo_s_ff} + lo_l_ff;
      lo_gap  = {1'b0, off_ff} - {1'b0, lo_s_ff};
      off_end = {1'b0, off_ff} + size_ff;
      hi_gap  = {1'b0, hi_s_ff} - {1'b0, off_ff};
   end

   // memory port selection
   always_comb begin
      ram_re      = 1'b0;
      ram_raddr   = scan_addr;
      ram_we_s    = 1'b0;
      ram_we_l    = 1'b0;
      ram_waddr   = lo_idx_ff;
      ram_wdata_s = hs_rd;
      ram_wdata_l = hl_rd;
      rem_start   = 1'b0;
      case (cmd.code)
         CMD_SCAN_RD: begin
            ram_re = 1'b1;
         end
         CMD_A_START: begin
            rem_start = 1'b1;
         end
         CMD_RM_RD: begin
            ram_re    = 1'b1;
            ram_raddr = mv_ff + CW'(1);
         end
         CMD_INS_RD: begin
            ram_re    = 1'b1;
            ram_raddr = mv_ff - CW'(1);
         end
         CMD_RM_WR, CMD_INS_WR: begin
            ram_we_s  = 1'b1;
            ram_we_l  = 1'b1;
            ram_waddr = mv_ff;
         end
         CMD_WR_BELOW, CMD_SPLIT: begin
            ram_we_l    = 1'b1;
            ram_wdata_l = below;
         end
         CMD_WR_TOP: begin
            ram_we_s    = 1'b1;
            ram_we_l    = 1'b1;
            ram_wdata_s = at_end[AW-1:0];
            ram_wdata_l = above;
         end
         CMD_MERGE2: begin
            ram_we_l    = 1'b1;
            ram_wdata_l = lo_l_ff + size_ff + hi_l_ff;
         end
         CMD_LO_GROW: begin
            ram_we_l    = 1'b1;
            ram_wdata_l = lo_l_ff + size_ff;
         end
         CMD_HI_GROW: begin
            ram_we_s    = 1'b1;
            ram_we_l    = 1'b1;
            ram_waddr   = hi_pos;
            ram_wdata_s = off_ff;
            ram_wdata_l = hi_l_ff + size_ff;
         end
         CMD_INS_PUT: begin
            ram_we_s    = 1'b1;
            ram_we_l    = 1'b1;
            ram_waddr   = ins_pos_ff;
            ram_wdata_s = ins_s_ff;
            ram_wdata_l = ins_l_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_start_ff <= '0;
         heap_size_ff  <= SPACE_END;
         default_ff    <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_HEAP_START: heap_start_ff <= csr_wdata[AW-1:0];
               CSR_HEAP_SIZE:  heap_size_ff  <= csr_wdata;
               CSR_DEFAULT:    default_ff    <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (cmd.code == CMD_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.code)
            CMD_CAPTURE: begin
               if (req_operation == OP_INIT) begin
                  cnt_ff <= '0;
               end
            end
            CMD_CNT_DEC: cnt_ff <= cnt_ff - CW'(1);
            CMD_INS_PUT: cnt_ff <= cnt_ff + CW'(1);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.code)
         CMD_CAPTURE: begin
            op_ff        <= req_operation;
            align_ff     <= req_alignment;
            strat_bad_ff <= (req_strategy == STRAT_BAD);
            // claim and free always scan upward
            down_ff      <= (req_operation == OP_ALLOC) &&
                            ((req_strategy == STRAT_DOWN) ||
                             ((req_strategy == STRAT_DEFAULT) && !default_ff));
            idx_ff       <= '0;
            lo_found_ff  <= 1'b0;
            hi_found_ff  <= 1'b0;
            if (req_operation == OP_INIT) begin
               off_ff  <= heap_start_ff;
               size_ff <= heap_size_ff;
               at_ff   <= heap_start_ff;
            end else begin
               off_ff  <= req_offset;
               size_ff <= req_size;
               at_ff   <= req_offset;
            end
         end
         CMD_SCAN_RD: rd_idx_ff <= scan_addr;
         CMD_NEXT:    idx_ff <= idx_ff + CW'(1);
         CMD_A_START: begin
            lo_idx_ff <= rd_idx_ff;
            lo_s_ff   <= hs_rd;
            lo_l_ff   <= hl_rd;
         end
         CMD_A_EVAL: begin
            at_ff  <= at_calc;
            idx_ff <= idx_ff + CW'(1);
         end
         CMD_F_LO: begin
            lo_found_ff <= 1'b1;
            lo_idx_ff   <= rd_idx_ff;
            lo_s_ff     <= hs_rd;
            lo_l_ff     <= hl_rd;
            idx_ff      <= idx_ff + CW'(1);
         end
         CMD_F_HI: begin
            hi_found_ff <= 1'b1;
            hi_s_ff     <= hs_rd;
            hi_l_ff     <= hl_rd;
         end
         CMD_RM_CARVE: mv_ff <= lo_idx_ff;
         CMD_MERGE2:   mv_ff <= lo_next;
         CMD_SPLIT: begin
            ins_pos_ff <= lo_next;
            ins_s_ff   <= at_end[AW-1:0];
            ins_l_ff   <= above;
            mv_ff      <= cnt_ff;
         end
         CMD_INS_FREE: begin
            ins_pos_ff <= hi_pos;
            ins_s_ff   <= off_ff;
            ins_l_ff   <= size_ff;
            mv_ff      <= cnt_ff;
         end
         CMD_RM_WR:  mv_ff <= mv_ff + CW'(1);
         CMD_INS_WR: mv_ff <= mv_ff - CW'(1);
         CMD_FINISH: begin
            rsp_status_ff <= cmd.status;
            rsp_placed_ff <= ((op_ff == OP_ALLOC) && (cmd.status == STATUS_OK)) ? at_ff : '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sts.op       = op_ff;
      sts.bad_req  = bad_req;
      sts.scan_end = (idx_ff == cnt_ff);
      sts.fits     = (size_ff <= hl_rd);
      sts.rem_done = rem_done;
      sts.place_ok = place_ok;
      sts.le_off   = (hs_rd <= off_ff);
      sts.claim_ok = lo_found_ff && (lo_l_ff >= lo_gap) && ((lo_l_ff - lo_gap) >= size_ff);
      sts.free_bad = (hi_found_ff && (size_ff > hi_gap)) ||
                     (lo_found_ff && (lo_end > {1'b0, off_ff}));
      sts.lo_adj   = lo_found_ff && (lo_end == {1'b0, off_ff});
      sts.hi_adj   = hi_found_ff && (off_end == {1'b0, hi_s_ff});
      sts.below0   = (below == '0);
      sts.above0   = (above == '0);
      sts.full     = (cnt_ff >= CW'(MAX_HOLES));
      sts.rm_more  = ((mv_ff + CW'(1)) < cnt_ff);
      sts.ins_more = (mv_ff > ins_pos_ff);
      sts.out_busy = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_placed_offset = rsp_placed_ff;

endmodule
`default_nettype wire

// ===== hdl/address_range_hole_allocator_unit.sv =====
`default_nettype none
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   operation, offset, size, alignment, strategy
// rsp      out        rsp_valid/rsp_stall   status, placed_offset
// csr      in         csr_wen               csr_index, csr_wdata
//
// One request at a time. A scan reads each visited hole in turn; each hole
// tried by allocate runs the bit-serial remainder unit before it is evaluated.
// Insert and remove shift the table entry by entry through the single RAM
// port pair. Reset clears the hole count, the CSRs and rsp_valid; no RAM sweep.
// A result held by rsp_stall stalls the finish step, not the next request.
module address_range_hole_allocator_unit #(
   parameter int MAX_HOLES = ahra_pkg::DEF_MAX_HOLES,
   parameter int ADDR_BITS = ahra_pkg::DEF_ADDR_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_operation,
   input  wire logic [ADDR_BITS-1:0] req_offset,
   input  wire logic [ADDR_BITS:0]   req_size,
   input  wire logic [ADDR_BITS:0]   req_alignment,
   input  wire logic [1:0]           req_strategy,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [1:0]           rsp_status,
   output logic      [ADDR_BITS-1:0] rsp_placed_offset,
   input  wire logic                 csr_wen,
   input  wire logic [1:0]           csr_index,
   input  wire logic [ADDR_BITS:0]   csr_wdata
);
   import ahra_pkg::*;

   ahra_cmd_type cmd;
   ahra_sts_type sts;

   ahra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ahra_dp #(.MAX_HOLES(MAX_HOLES), .ADDR_BITS(ADDR_BITS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_offset        (req_offset),
      .req_size          (req_size),
      .req_alignment     (req_alignment),
      .req_strategy      (req_strategy),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_placed_offset (rsp_placed_offset),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule
`default_nettype wire

// ===== test/address_range_hole_allocator_unit_test.sv =====
module address_range_hole_allocator_unit_test;
   import ahra_pkg::*;

   localparam int NHOLES = 64;
   localparam int AB = 48;
   localparam logic [AB:0] SPACE_END = 49'h1_0000_0000_0000;
   localparam int WATCHDOG_LIMIT = 400000;

   typedef struct packed {
      logic [1:0]    status;
      logic [AB-1:0] placed;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = OP_INIT;
   logic [AB-1:0] req_offset = '0;
   logic [AB:0] req_size = '0;
   logic [AB:0] req_alignment = '0;
   logic [1:0] req_strategy = STRAT_DEFAULT;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [AB-1:0] rsp_placed_offset;
   logic csr_wen = 1'b0;
   logic [1:0] csr_index = CSR_HEAP_START;
   logic [AB:0] csr_wdata = '0;

   address_range_hole_allocator_unit DUT (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [AB-1:0] cfg_start;
   logic [AB:0] cfg_size;
   logic cfg_up;
   logic [AB-1:0] tbl_start[NHOLES];
   logic [AB:0] tbl_len[NHOLES];
   int tbl_count;

   alloc_result_type pending_results[$];
   int errors = 0;
   int idle_cycles = 0;
   bit rsp_random_stall = 1'b1;

   task automatic report_mismatch(input string what, input logic [AB:0] got,
                                  input logic [AB:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic void tbl_remove(int p);
      for (int i = p; i < tbl_count - 1; i++) begin
         tbl_start[i] = tbl_start[i+1];
         tbl_len[i] = tbl_len[i+1];
      end
      tbl_count--;
   endfunction

   function automatic void tbl_insert(int p, logic [AB-1:0] s, logic [AB:0] l);
      for (int i = tbl_count; i > p; i--) begin
         tbl_start[i] = tbl_start[i-1];
         tbl_len[i] = tbl_len[i-1];
      end
      tbl_start[p] = s;
      tbl_len[p] = l;
      tbl_count++;
   endfunction

   function automatic logic [1:0] carve_hole(int p, logic [63:0] at, logic [63:0] len);
      logic [63:0] hs, hl, below, above;
      hs = 64'(tbl_start[p]);
      hl = 64'(tbl_len[p]);
      below = at - hs;
      above = hl - len - below;
      if (below == 0 && above == 0) tbl_remove(p);
      else if (above == 0) tbl_len[p] = below[AB:0];
      else if (below == 0) begin
         tbl_start[p] = AB'(hs + len);
         tbl_len[p] = above[AB:0];
      end else begin
         if (tbl_count >= NHOLES) return STATUS_FULL;
         tbl_len[p] = below[AB:0];
         tbl_insert(p + 1, AB'(at + len), above[AB:0]);
      end
      return STATUS_OK;
   endfunction

   function automatic int hole_at_or_below(logic [63:0] a);
      int r;
      r = tbl_count;
      for (int i = 0; i < tbl_count; i++) begin
         if (64'(tbl_start[i]) <= a) r = i;
         else break;
      end
      return r;
   endfunction

   function automatic logic [1:0] free_range(logic [63:0] off, logic [63:0] size);
      int lo, hi;
      bit has_lo, has_hi, lo_adj, hi_adj;
      if (size == 0 || size > SPACE_END - off) return STATUS_INVALID;
      lo = hole_at_or_below(off);
      has_lo = lo < tbl_count;
      hi = has_lo ? lo + 1 : 0;
      has_hi = hi < tbl_count;
      if (has_hi && size > 64'(tbl_start[hi]) - off) return STATUS_INVALID;
      if (has_lo && 64'(tbl_start[lo]) + tbl_len[lo] > off) return STATUS_INVALID;
      lo_adj = has_lo && (64'(tbl_start[lo]) + tbl_len[lo] == off);
      hi_adj = has_hi && (off + size == 64'(tbl_start[hi]));
      if (lo_adj && hi_adj) begin
         tbl_len[lo] = (AB+1)'(64'(tbl_len[lo]) + size + tbl_len[hi]);
         tbl_remove(hi);
      end else if (lo_adj) tbl_len[lo] = (AB+1)'(64'(tbl_len[lo]) + size);
      else if (hi_adj) begin
         tbl_start[hi] = off[AB-1:0];
         tbl_len[hi] = (AB+1)'(64'(tbl_len[hi]) + size);
      end else begin
         if (tbl_count >= NHOLES) return STATUS_FULL;
         tbl_insert(hi, off[AB-1:0], size[AB:0]);
      end
      return STATUS_OK;
   endfunction

   function automatic alloc_result_type predict_request(logic [1:0] op, logic [AB-1:0] off,
                                                      logic [AB:0] size, logic [AB:0] align,
                                                      logic [1:0] strat);
      alloc_result_type r;
      logic [63:0] hs, hl, at, mis;
      int p, q;
      bit down;
      r.status = STATUS_NOFIT;
      r.placed = '0;
      case (op)
         OP_ALLOC: begin
            if (size == 0 || align == 0 || strat == STRAT_BAD) r.status = STATUS_INVALID;
            else begin
               down = (strat == STRAT_DEFAULT) ? !cfg_up : (strat == STRAT_DOWN);
               for (int i = 0; i < tbl_count; i++) begin
                  p = down ? tbl_count - 1 - i : i;
                  hs = 64'(tbl_start[p]);
                  hl = 64'(tbl_len[p]);
                  if (size > hl) continue;
                  if (down) begin
                     at = ((hs + hl - size) / align) * align;
                     if (at < hs) continue;
                  end else begin
                     mis = hs % align;
                     at = hs;
                     if (mis != 0) begin
                        if (align - mis > hl - size) continue;
                        at = hs + align - mis;
                     end
                  end
                  r.status = carve_hole(p, at, 64'(size));
                  if (r.status == STATUS_OK) r.placed = at[AB-1:0];
                  break;
               end
            end
         end
         OP_CLAIM: begin
            if (size == 0 || 64'(size) > SPACE_END - off) r.status = STATUS_INVALID;
            else begin
               q = hole_at_or_below(64'(off));
               if (q < tbl_count && 64'(tbl_len[q]) >= 64'(off - tbl_start[q])
                   && 64'(tbl_len[q]) - (off - tbl_start[q]) >= size)
                  r.status = carve_hole(q, 64'(off), 64'(size));
            end
         end
         OP_FREE: r.status = free_range(64'(off), 64'(size));
         default: begin
            tbl_count = 0;
            r.status = free_range(64'(cfg_start), 64'(cfg_size));
         end
      endcase
      return r;
   endfunction

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(input logic [1:0] op, input logic [AB-1:0] off,
                               input logic [AB:0] size, input logic [AB:0] align,
                               input logic [1:0] strat);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_offset <= off;
      req_size <= size;
      req_alignment <= align;
      req_strategy <= strat;
      pending_results.push_back(predict_request(op, off, size, align, strat));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [AB:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_HEAP_START: cfg_start = value[AB-1:0];
         CSR_HEAP_SIZE: cfg_size = value;
         default: cfg_up = value[0];
      endcase
   endtask

   task automatic configure(input logic [AB-1:0] s, input logic [AB:0] l, input logic up);
      drain();
      write_csr(CSR_HEAP_START, {1'b0, s});
      write_csr(CSR_HEAP_SIZE, l);
      write_csr(CSR_DEFAULT, {48'd0, up});
   endtask

   function automatic logic [AB:0] rand49();
      logic [AB:0] v;
      v = (AB+1)'({$urandom, $urandom});
      case ($urandom_range(0, 5))
         0: return v;
         1: return v & 49'hFFF;
         2: return 49'(1) << $urandom_range(0, 48);
         3: return v & 49'hFF_FFFF;
         default: return v & 49'hFFFF;
      endcase
   endfunction

   // rsp side: random stall, check each result beat against the oldest prediction
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected beat", {1'b0, rsp_placed_offset}, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", (AB+1)'(rsp_status), (AB+1)'(want.status));
               if (rsp_placed_offset !== want.placed)
                  report_mismatch("placed_offset", {1'b0, rsp_placed_offset},
                                  {1'b0, want.placed});
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
      rsp_stall <= rsp_random_stall && ($urandom_range(0, 99) < 25) ?
                   1'b1 : ($urandom_range(0, 99) < 2);
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("address_range_hole_allocator_unit_test failed");
         $finish;
      end
   end

   task automatic test_invalid_and_empty();
      send_request(OP_ALLOC, '0, 49'd16, 49'd1, STRAT_DEFAULT);
      send_request(OP_INIT, '0, '0, '0, STRAT_DEFAULT);
      send_request(OP_ALLOC, '0, '0, 49'd1, STRAT_UP);
      send_request(OP_ALLOC, '0, 49'd1, '0, STRAT_UP);
      send_request(OP_ALLOC, '0, 49'd1, 49'd1, STRAT_BAD);
      send_request(OP_CLAIM, 48'hFFFF_FFFF_FFFF, 49'd2, '0, STRAT_DEFAULT);
      send_request(OP_FREE, '0, '0, '0, STRAT_DEFAULT);
      send_request(OP_ALLOC, '0, SPACE_END, 49'd1, STRAT_DOWN);
      send_request(OP_FREE, '0, 49'd1, '0, STRAT_DEFAULT);
   endtask

   task automatic test_carve_cases();
      configure(48'h1000, 49'h1000, 1'b0);
      send_request(OP_INIT, '0, '0, '0, STRAT_DEFAULT);
      send_request(OP_ALLOC, '0, 49'h10, 49'h7, STRAT_DOWN);
      send_request(OP_ALLOC, '0, 49'h10, 49'h30, STRAT_UP);
      send_request(OP_CLAIM, 48'h1800, 49'h20, '0, STRAT_DEFAULT);
      send_request(OP_CLAIM, 48'h1800, 49'h20, '0, STRAT_DEFAULT);
      send_request(OP_FREE, 48'h1810, 49'h20, '0, STRAT_DEFAULT);
      send_request(OP_FREE, 48'h1800, 49'h20, '0, STRAT_DEFAULT);
      send_request(OP_CLAIM, 48'h1000, 49'h1000, '0, STRAT_DEFAULT);
      send_request(OP_FREE, 48'h1000, 49'h1000, '0, STRAT_DEFAULT);
      send_request(OP_ALLOC, '0, 49'h1000, SPACE_END, STRAT_DEFAULT);
      send_request(OP_ALLOC, '0, 49'h800, 49'h800, STRAT_DEFAULT);
      configure(48'hFFFF_FFFF_FFF0, 49'h20, 1'b1);
      send_request(OP_INIT, '0, '0, '0, STRAT_DEFAULT);
      configure(48'hFFFF_FFFF_FFF0, 49'h10, 1'b1);
      send_request(OP_INIT, '0, '0, '0, STRAT_DEFAULT);
      send_request(OP_ALLOC, '0, 49'h1, 49'h3, STRAT_DEFAULT);
   endtask

   task automatic test_table_full();
      configure(48'h0, 49'h400, 1'b1);
      send_request(OP_INIT, '0, '0, '0, STRAT_DEFAULT);
      for (int i = 0; i < 70; i++)
         send_request(OP_CLAIM, 48'(16 * i + 4), 49'd4, '0, STRAT_DEFAULT);
      send_request(OP_FREE, 48'h3F0, 49'd2, '0, STRAT_DEFAULT);
   endtask

   task automatic test_random(input int n);
      logic [1:0] op;
      logic [AB-1:0] off;
      logic [AB:0] sz;
      int k;
      for (int i = 0; i < n; i++) begin
         if (i % 200 == 0) begin
            k = $urandom_range(0, 3);
            if (k == 0) configure('0, SPACE_END, 1'($urandom_range(0, 1)));
            else if (k == 1) configure(48'hFFFF_FFFF_F000, 49'h1000, 1'($urandom_range(0, 1)));
            else configure(AB'({$urandom, $urandom} & 64'hFFFF_FFFF_0000), 49'h2_0000,
                           1'($urandom_range(0, 1)));
            send_request(OP_INIT, '0, '0, '0, STRAT_DEFAULT);
         end
         k = $urandom_range(0, 99);
         op = k < 40 ? OP_ALLOC : k < 60 ? OP_CLAIM : k < 98 ? OP_FREE : OP_INIT;
         sz = (k % 3 == 0) ? rand49() : 49'($urandom_range(1, 600));
         off = (cfg_size > 49'h1_0000) ? AB'({$urandom, $urandom})
               : cfg_start + 48'($urandom_range(0, 32'(cfg_size) + 64));
         if ($urandom_range(0, 19) == 0) off = AB'({$urandom, $urandom});
         if (op == OP_FREE && $urandom_range(0, 1) == 0) sz = 49'($urandom_range(1, 64));
         send_request(op, off, sz, $urandom_range(0, 9) == 0 ? rand49()
                      : 49'($urandom_range(1, 64)), 2'($urandom_range(0, 3)));
      end
   endtask

   initial begin
      cfg_start = '0;
      cfg_size = SPACE_END;
      cfg_up = 1'b0;
      tbl_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_invalid_and_empty();
      test_carve_cases();
      test_table_full();
      rsp_random_stall = 1'b0;
      test_random(150);
      rsp_random_stall = 1'b1;
      test_random(900);
      drain();
      if (errors == 0) $display("address_range_hole_allocator_unit_test passed");
      else $display("address_range_hole_allocator_unit_test failed");
      $finish;
   end

endmodule
